[src/assert_macros.svh]
// Assertion macros used by the checker file.
// Every macro samples on the rising edge of clock and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[src/pota_pkg.sv]
// Shared types, constants and helper functions of the power-of-two allocator.
// Used by the control, top-level and checker modules; depends on nothing.
package pota_pkg;

   localparam int NUM_PAGES   = 16;
   localparam int PAGE_BYTES  = 4096;
   localparam int MIN_BLOCK   = 16;
   localparam int NUM_CLASSES = 9;
   localparam int PAGE_W      = 4;
   localparam int OFF_W       = 12;
   localparam int UNIT_W      = 12;
   localparam int LINK_W      = 13;
   localparam int CLS_W       = 4;
   localparam int CNT_W       = 5;
   localparam int BLK_W       = 8;
   localparam int MINSH       = 4;
   localparam int UNITS       = NUM_PAGES * (PAGE_BYTES / MIN_BLOCK);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_BIG  = 2'd1;
   localparam logic [1:0] ST_NO_MEM   = 2'd2;

   typedef struct packed {
      logic        command;
      logic [15:0] request_size;
      logic [15:0] block_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_address;
      logic [12:0] granted_size;
   } rsp_type;

   typedef struct packed {
      logic              write_enable;
      logic [UNIT_W-1:0] addr;
      logic [LINK_W-1:0] wdata;
   } ram_req_type;

   // Smallest class whose block holds the request; callers guarantee
   // the request does not exceed one page.
   function automatic logic [CLS_W-1:0] class_of(input logic [15:0] req);
      logic [CLS_W-1:0] cls;
      cls = CLS_W'(NUM_CLASSES - 1);
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ({1'b0, req} <= 17'(MIN_BLOCK << c)) begin
            cls = CLS_W'(c);
         end
      end
      return cls;
   endfunction

endpackage

[src/pota_ram.sv]
// Generic single-port RAM with registered read data.
// Standalone; used for the free-list link store.
module pota_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[src/pota_ctrl.sv]
// Sequencer of the allocator: class heads, page table, carving walk.
// Depends on pota_pkg; drives the link RAM through a request struct.
module pota_ctrl import pota_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CNT_W-1:0]  csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_word,
   output ram_req_type       ram_req,
   input  logic [LINK_W-1:0] ram_rdata,
   input  logic              res_free,
   output logic              res_load,
   output rsp_type           res_word
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_POP    = 3'd2;
   localparam logic [2:0] S_CARVE  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   rsp_type           result_ff, result_in;
   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [BLK_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pages_used_ff, pages_used_in;
   logic [CNT_W-1:0]  page_limit_ff;
   logic [LINK_W-1:0] head_ff [NUM_CLASSES];
   logic [CLS_W-1:0]  page_class_ff [NUM_PAGES];

   logic              head_we;
   logic [CLS_W-1:0]  head_idx;
   logic [LINK_W-1:0] head_wdata;
   logic              pc_we;

   logic [PAGE_W-1:0] f_page;
   logic [OFF_W-1:0]  f_off;
   logic [CLS_W-1:0]  f_cls;
   logic [OFF_W-1:0]  f_mask;
   logic              f_ok;
   logic [CLS_W-1:0]  a_cls;
   logic [CNT_W-1:0]  limit;
   logic [BLK_W-1:0]  carve_off;
   logic [LINK_W-1:0] head_rd;

   assign req_stall = (state_ff != S_IDLE);
   assign res_word  = result_ff;

   always_comb begin
      f_page    = item_ff.block_address[15:OFF_W];
      f_off     = item_ff.block_address[OFF_W-1:0];
      f_cls     = page_class_ff[f_page];
      f_mask    = OFF_W'((13'd1 << (f_cls + CLS_W'(MINSH))) - 13'd1);
      f_ok      = ({1'b0, f_page} < pages_used_ff) && ((f_off & f_mask) == '0);
      a_cls     = class_of(item_ff.request_size);
      limit     = (page_limit_ff > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : page_limit_ff;
      carve_off = BLK_W'(idx_ff << cls_ff);
      head_rd   = head_ff[(state_ff == S_DECODE) ?
                          ((item_ff.command == CMD_FREE) ? f_cls : a_cls) : cls_ff];
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      result_in     = result_ff;
      cls_in        = cls_ff;
      page_in       = page_ff;
      idx_in        = idx_ff;
      pages_used_in = pages_used_ff;
      head_we       = 1'b0;
      head_idx      = cls_ff;
      head_wdata    = '0;
      pc_we         = 1'b0;
      ram_req       = '0;
      res_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            result_in = '0;
            state_in  = S_RESP;
            if (item_ff.command == CMD_FREE) begin
               if (f_ok) begin
                  ram_req.write_enable = 1'b1;
                  ram_req.addr         = item_ff.block_address[15:MINSH];
                  ram_req.wdata        = head_rd;
                  head_we    = 1'b1;
                  head_idx   = f_cls;
                  head_wdata = LINK_W'(item_ff.block_address[15:MINSH]) + LINK_W'(1);
               end
            end else if ({1'b0, item_ff.request_size} > 17'(PAGE_BYTES)) begin
               result_in.status = ST_TOO_BIG;
            end else begin
               cls_in = a_cls;
               if (head_rd != '0) begin
                  // Read the link of the head block; the data returns next cycle.
                  ram_req.addr              = UNIT_W'(head_rd - LINK_W'(1));
                  result_in.granted_address = {UNIT_W'(head_rd - LINK_W'(1)), 4'd0};
                  result_in.granted_size    = 13'(MIN_BLOCK << a_cls);
                  state_in                  = S_POP;
               end else if (pages_used_ff >= limit) begin
                  result_in.status = ST_NO_MEM;
               end else begin
                  pc_we                     = 1'b1;
                  page_in                   = PAGE_W'(pages_used_ff);
                  pages_used_in             = pages_used_ff + CNT_W'(1);
                  idx_in                    = BLK_W'((9'd256 >> a_cls) - 9'd1);
                  result_in.granted_address = {PAGE_W'(pages_used_ff), 12'd0};
                  result_in.granted_size    = 13'(MIN_BLOCK << a_cls);
                  if (a_cls != CLS_W'(NUM_CLASSES - 1)) begin
                     state_in = S_CARVE;
                  end
               end
            end
         end
         S_POP: begin
            head_we    = 1'b1;
            head_wdata = ram_rdata;
            state_in   = S_RESP;
         end
         S_CARVE: begin
            // Push blocks from the top of the page down so block 1 ends at the head.
            ram_req.write_enable = 1'b1;
            ram_req.addr         = {page_ff, carve_off};
            ram_req.wdata        = head_rd;
            head_we    = 1'b1;
            head_wdata = LINK_W'({page_ff, carve_off}) + LINK_W'(1);
            idx_in     = idx_ff - BLK_W'(1);
            if (idx_ff == BLK_W'(1)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (res_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pages_used_ff <= '0;
         page_limit_ff <= CNT_W'(NUM_PAGES);
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pages_used_ff <= pages_used_in;
         if (csr_write_enable) begin
            page_limit_ff <= csr_write_data;
         end
         if (head_we) begin
            head_ff[head_idx] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
      cls_ff    <= cls_in;
      page_ff   <= page_in;
      idx_ff    <= idx_in;
      if (pc_we) begin
         page_class_ff[PAGE_W'(pages_used_ff)] <= a_cls;
      end
   end

endmodule

[src/power_of_two_block_allocator.sv]
// Power-of-two block allocator: 16 pages of 4096 bytes, blocks of 16 to 4096 bytes.
// Each command passes through decode and then a result state that loads the output word;
// a pop from a free list adds a link read state, and a new page adds carving of its spare blocks.
// One command at a time: the next word can be accepted in the same cycle that the result
// word appears; a stalled result holds the input.
// Synchronous active-high reset empties all lists and sets the page limit to 16.
module power_of_two_block_allocator import pota_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_word
);

   ram_req_type       ram_req;
   logic [LINK_W-1:0] ram_rdata;
   logic              res_load;
   rsp_type           res_word;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;

   pota_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .ram_req          (ram_req),
      .ram_rdata        (ram_rdata),
      .res_free         (!rsp_valid_ff || !rsp_stall),
      .res_load         (res_load),
      .res_word         (res_word)
   );

   pota_ram #(
      .WIDTH (LINK_W),
      .DEPTH (UNITS)
   ) u_link_ram (
      .clock        (clock),
      .write_enable (ram_req.write_enable),
      .addr         (ram_req.addr),
      .wdata        (ram_req.wdata),
      .rdata        (ram_rdata)
   );

   // Output word register; it holds while the consumer stalls.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[src/pota_checker.sv]
// Port-level checker for the allocator, bound to the top level.
// Depends on pota_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pota_checker import pota_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_word
);

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "rsp word changed while stalled")
   `ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second word accepted while busy")
   `ASSERT_IMPLY(a_status_code, rsp_valid, rsp_word.status != 2'd3, "undefined status code")
   `ASSERT_IMPLY(a_fail_zero, rsp_valid && (rsp_word.status != ST_OK), (rsp_word.granted_address == '0) && (rsp_word.granted_size == '0), "failure word carries a grant")
   `ASSERT_CLK(a_size_pow2, !(rsp_valid && (rsp_word.granted_size != '0)) || ($onehot(rsp_word.granted_size) && (rsp_word.granted_size >= 13'(MIN_BLOCK))), "granted size is not a valid class size")

endmodule

bind power_of_two_block_allocator pota_checker u_pota_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
